// ===== rtl/core/qsfd_pkg.sv =====
// types and constants shared by the quad shape function derivative pipeline
// no dependencies; imported by qsfd_issue, qsfd_lane and the top level
package qsfd_pkg;

  localparam int XIW      = 18;  // coordinate field width
  localparam int NODEW    = 4;   // node index width
  localparam int DW       = 19;  // derivative field width
  localparam int TDIN_W   = 40;  // in word: xi, gamma, padded to bytes
  localparam int TDOUT_W  = 48;  // out word: node_index, deriv_xi, deriv_gamma, padded
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int OUT_MAX  = 262143;
  localparam int OUT_MIN  = -262144;
  localparam int NODES_BILIN  = 4;
  localparam int NODES_BIQUAD = 9;

  // register index
  localparam logic REG_ELEMENT_MODE = 1'b0;

  typedef enum logic {
    MODE_BILIN  = 1'b0,
    MODE_BIQUAD = 1'b1
  } elem_mode_t;

  // first product p * q
  typedef enum logic [2:0] {
    P_TM, P_TP, P_SM, P_SP, P_X, P_G
  } p_sel_t;

  typedef enum logic [1:0] {
    Q_ONE, Q_X, Q_G
  } q_sel_t;

  // what is done with the rounded first product
  typedef enum logic [1:0] {
    POST_POS, POST_NEG, POST_CMP
  } post_t;

  // second factor
  typedef enum logic [3:0] {
    B_S2M, B_S2P, B_T2M, B_T2P, B_TM, B_TP, B_SM, B_SP, B_NS2, B_NT2, B_ONE
  } b_sel_t;

  // final rounding shift: frac, frac+1, frac+2
  typedef enum logic [1:0] {
    SH_0, SH_1, SH_2
  } sh_t;

  typedef struct packed {
    p_sel_t p_sel;
    q_sel_t q_sel;
    post_t  post;
    b_sel_t b_sel;
    sh_t    sh;
  } op_t;

  typedef struct packed {
    logic             vld;
    logic [NODEW-1:0] node;
    logic             last;
  } ctrl_t;

endpackage

// ===== rtl/core/qsfd_issue.sv =====
// point register and node sequencer: clamps a point and issues one node per cycle
// unless stalled, with operand selects for both derivative lanes; uses qsfd_pkg
module qsfd_issue import qsfd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [XIW-1:0]       in_xi,
  input  logic signed [XIW-1:0]       in_gamma,
  input  elem_mode_t                  mode,
  input  logic                        adv,
  output ctrl_t                       iss,
  output logic signed [FRAC_BITS+1:0] iss_x,
  output logic signed [FRAC_BITS+1:0] iss_g,
  output op_t                         op_x,
  output op_t                         op_g
);

  localparam int CW = FRAC_BITS + 2;
  localparam int EW = FRAC_BITS + XIW + 2;

  logic                 pt_valid_r, pt_valid_nxt;
  logic [NODEW-1:0]     k_r, k_nxt;
  logic signed [CW-1:0] x_r, g_r;
  logic                 accept, last;

  function automatic logic signed [CW-1:0] clamp(input logic signed [XIW-1:0] raw);
    logic signed [EW-1:0] v;
    logic signed [EW-1:0] one;
    v   = EW'(raw);
    one = EW'(1) << FRAC_BITS;
    if (v > one) begin
      v = one;
    end
    if (v < -one) begin
      v = -one;
    end
    return v[CW-1:0];
  endfunction

  function automatic op_t mk_op(input p_sel_t p, input q_sel_t q, input post_t post,
                                input b_sel_t b, input sh_t sh);
    op_t o;
    o.p_sel = p;
    o.q_sel = q;
    o.post  = post;
    o.b_sel = b;
    o.sh    = sh;
    return o;
  endfunction

  always_comb begin
    if (mode == MODE_BIQUAD) begin
      last = (k_r == NODEW'(NODES_BIQUAD - 1));
    end else begin
      last = (k_r == NODEW'(NODES_BILIN - 1));
    end
    in_ready     = !pt_valid_r || (adv && last);
    accept       = in_valid && in_ready;
    pt_valid_nxt = pt_valid_r;
    k_nxt        = k_r;
    if (accept) begin
      pt_valid_nxt = 1'b1;
      k_nxt        = '0;
    end else if (pt_valid_r && adv) begin
      if (last) begin
        pt_valid_nxt = 1'b0;
      end else begin
        k_nxt = k_r + NODEW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r <= 1'b0;
      k_r        <= '0;
    end else begin
      pt_valid_r <= pt_valid_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= clamp(in_xi);
      g_r <= clamp(in_gamma);
    end
  end

  assign iss.vld  = pt_valid_r;
  assign iss.node = k_r;
  assign iss.last = last;
  assign iss_x    = x_r;
  assign iss_g    = g_r;

  // per node: d = rnd(post(rnd(p*q)) * b)
  always_comb begin
    op_x = mk_op(P_X, Q_ONE, POST_POS, B_ONE, SH_0);
    op_g = mk_op(P_X, Q_ONE, POST_POS, B_ONE, SH_0);
    if (mode == MODE_BILIN) begin
      unique case (k_r)
        4'd0: begin
          op_x = mk_op(P_TM, Q_ONE, POST_POS, B_ONE, SH_2);
          op_g = mk_op(P_SM, Q_ONE, POST_POS, B_ONE, SH_2);
        end
        4'd1: begin
          op_x = mk_op(P_TM, Q_ONE, POST_NEG, B_ONE, SH_2);
          op_g = mk_op(P_SP, Q_ONE, POST_NEG, B_ONE, SH_2);
        end
        4'd2: begin
          op_x = mk_op(P_TP, Q_ONE, POST_POS, B_ONE, SH_2);
          op_g = mk_op(P_SP, Q_ONE, POST_POS, B_ONE, SH_2);
        end
        4'd3: begin
          op_x = mk_op(P_TP, Q_ONE, POST_NEG, B_ONE, SH_2);
          op_g = mk_op(P_SM, Q_ONE, POST_NEG, B_ONE, SH_2);
        end
        default: begin
          op_x = mk_op(P_X, Q_ONE, POST_POS, B_ONE, SH_0);
          op_g = mk_op(P_X, Q_ONE, POST_POS, B_ONE, SH_0);
        end
      endcase
    end else begin
      unique case (k_r)
        4'd0: begin
          op_x = mk_op(P_TM, Q_G, POST_POS, B_S2M, SH_2);
          op_g = mk_op(P_SM, Q_X, POST_POS, B_T2M, SH_2);
        end
        4'd1: begin
          op_x = mk_op(P_TM, Q_G, POST_POS, B_S2P, SH_2);
          op_g = mk_op(P_SP, Q_X, POST_POS, B_T2M, SH_2);
        end
        4'd2: begin
          op_x = mk_op(P_TP, Q_G, POST_POS, B_S2P, SH_2);
          op_g = mk_op(P_SP, Q_X, POST_POS, B_T2P, SH_2);
        end
        4'd3: begin
          op_x = mk_op(P_TP, Q_G, POST_POS, B_S2M, SH_2);
          op_g = mk_op(P_SM, Q_X, POST_POS, B_T2P, SH_2);
        end
        4'd4: begin
          op_x = mk_op(P_X, Q_G, POST_NEG, B_TM, SH_0);
          op_g = mk_op(P_X, Q_X, POST_CMP, B_T2M, SH_1);
        end
        4'd5: begin
          op_x = mk_op(P_G, Q_G, POST_CMP, B_S2P, SH_1);
          op_g = mk_op(P_X, Q_G, POST_NEG, B_SP, SH_0);
        end
        4'd6: begin
          op_x = mk_op(P_X, Q_G, POST_NEG, B_TP, SH_0);
          op_g = mk_op(P_X, Q_X, POST_CMP, B_T2P, SH_1);
        end
        4'd7: begin
          op_x = mk_op(P_G, Q_G, POST_CMP, B_S2M, SH_1);
          op_g = mk_op(P_X, Q_G, POST_NEG, B_SM, SH_0);
        end
        4'd8: begin
          op_x = mk_op(P_G, Q_G, POST_CMP, B_NS2, SH_0);
          op_g = mk_op(P_X, Q_X, POST_CMP, B_NT2, SH_0);
        end
        default: begin
          op_x = mk_op(P_X, Q_ONE, POST_POS, B_ONE, SH_0);
          op_g = mk_op(P_X, Q_ONE, POST_POS, B_ONE, SH_0);
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/qsfd_lane.sv =====
// one derivative lane: operand select, two multiply stages with rounding,
// saturation into the output register; five register stages; uses qsfd_pkg
module qsfd_lane import qsfd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [FRAC_BITS+1:0] x,
  input  logic signed [FRAC_BITS+1:0] g,
  input  op_t                         op,
  output logic signed [DW-1:0]        deriv
);

  localparam int LW = FRAC_BITS + 3;
  localparam int PW = 2 * LW;
  localparam logic signed [LW-1:0] ONE_L  = LW'(1) << FRAC_BITS;
  localparam logic signed [PW:0]   RND_F0 = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW:0]   RND_F1 = (PW+1)'(1) << FRAC_BITS;
  localparam logic signed [PW:0]   RND_F2 = (PW+1)'(1) << (FRAC_BITS + 1);
  localparam logic signed [PW:0]   OMAX_W = (PW+1)'(OUT_MAX);
  localparam logic signed [PW:0]   OMIN_W = (PW+1)'(OUT_MIN);

  logic signed [LW-1:0] xe, ge, s2, t2;
  logic signed [LW-1:0] p_nxt, q_nxt, b_nxt;
  logic signed [LW-1:0] p_r, q_r, b1_r, b2_r, b3_r;
  post_t                post1_r, post2_r;
  sh_t                  sh1_r, sh2_r, sh3_r, sh4_r;
  logic signed [PW-1:0] prod1_nxt, prod1_r;
  logic signed [PW:0]   sum1;
  logic signed [PW:0]   rp1;
  logic signed [LW-1:0] pv, a_nxt, a_r;
  logic signed [PW-1:0] prod2_nxt, prod2_r;
  logic signed [PW:0]   sum_0, sum_1, sum_2, rv;
  logic signed [DW-1:0] deriv_nxt, deriv_r;

  // stage 1: linear terms and operand select
  always_comb begin
    xe = LW'(x);
    ge = LW'(g);
    s2 = xe <<< 1;
    t2 = ge <<< 1;
    case (op.p_sel)
      P_TM:    p_nxt = ge - ONE_L;
      P_TP:    p_nxt = ge + ONE_L;
      P_SM:    p_nxt = xe - ONE_L;
      P_SP:    p_nxt = xe + ONE_L;
      P_G:     p_nxt = ge;
      default: p_nxt = xe;
    endcase
    case (op.q_sel)
      Q_X:     q_nxt = xe;
      Q_G:     q_nxt = ge;
      default: q_nxt = ONE_L;
    endcase
    case (op.b_sel)
      B_S2M:   b_nxt = s2 - ONE_L;
      B_S2P:   b_nxt = s2 + ONE_L;
      B_T2M:   b_nxt = t2 - ONE_L;
      B_T2P:   b_nxt = t2 + ONE_L;
      B_TM:    b_nxt = ge - ONE_L;
      B_TP:    b_nxt = ge + ONE_L;
      B_SM:    b_nxt = xe - ONE_L;
      B_SP:    b_nxt = xe + ONE_L;
      B_NS2:   b_nxt = -s2;
      B_NT2:   b_nxt = -t2;
      default: b_nxt = ONE_L;
    endcase
  end

  // stage 3: round first product, then negate or take one minus it
  always_comb begin
    prod1_nxt = p_r * q_r;
    sum1      = (PW+1)'(prod1_r) + RND_F0;
    rp1       = sum1 >>> FRAC_BITS;
    pv        = rp1[LW-1:0];
    case (post2_r)
      POST_NEG: a_nxt = -pv;
      POST_CMP: a_nxt = ONE_L - pv;
      default:  a_nxt = pv;
    endcase
  end

  // stage 5: final rounding with a per-node shift, then saturate
  always_comb begin
    prod2_nxt = a_r * b3_r;
    sum_0     = (PW+1)'(prod2_r) + RND_F0;
    sum_1     = (PW+1)'(prod2_r) + RND_F1;
    sum_2     = (PW+1)'(prod2_r) + RND_F2;
    case (sh4_r)
      SH_1:    rv = sum_1 >>> (FRAC_BITS + 1);
      SH_2:    rv = sum_2 >>> (FRAC_BITS + 2);
      default: rv = sum_0 >>> FRAC_BITS;
    endcase
    if (rv > OMAX_W) begin
      deriv_nxt = DW'(OUT_MAX);
    end else if (rv < OMIN_W) begin
      deriv_nxt = DW'(OUT_MIN);
    end else begin
      deriv_nxt = rv[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      b1_r    <= b_nxt;
      post1_r <= op.post;
      sh1_r   <= op.sh;
      prod1_r <= prod1_nxt;
      b2_r    <= b1_r;
      post2_r <= post1_r;
      sh2_r   <= sh1_r;
      a_r     <= a_nxt;
      b3_r    <= b2_r;
      sh3_r   <= sh2_r;
      prod2_r <= prod2_nxt;
      sh4_r   <= sh3_r;
      deriv_r <= deriv_nxt;
    end
  end

  assign deriv = deriv_r;

endmodule

// ===== rtl/core/quad_shape_function_derivatives.sv =====
// top level of the quad4/quad9 shape function derivative pipeline
// uses qsfd_pkg, qsfd_issue and two qsfd_lane instances
//
//  channel  | dir | handshake          | word
//  in_      | in  | tvalid/tready      | tdata: xi[17:0], gamma[35:18]
//  out_     | out | tvalid/tready/tlast| tdata: node_index, deriv_xi, deriv_gamma
//  cfg_     | in  | apb psel/penable   | element_mode at byte address 0
//
// one node result per cycle unless the result word stalls: a point takes 4 words (4-node mode)
// or 9 words (9-node mode) of the single result channel; the node sequencer sets that figure.
// after its point is accepted, the first result word passes the point register, then five lane stages.
// reset clears the mode to 4-node and empties the pipeline.
// a stalled result word freezes the whole pipeline; the next point is taken
// in the same cycle as the last node of the current one is issued.
module quad_shape_function_derivatives import qsfd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDIN_W-1:0]  in_tdata,    // xi[17:0], gamma[35:18], zero pad
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDOUT_W-1:0] out_tdata,   // node_index[3:0], deriv_xi[22:4], deriv_gamma[41:23], zero pad
  output logic               out_tlast,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int NSTG = 5;
  localparam int PADW = TDOUT_W - NODEW - 2 * DW;

  elem_mode_t                  mode_r, mode_nxt;
  logic                        adv, reg_hit;
  ctrl_t                       iss;
  ctrl_t                       ctrl_r [1:NSTG];
  logic signed [FRAC_BITS+1:0] iss_x, iss_g;
  op_t                         op_x, op_g;
  logic signed [DW-1:0]        deriv_x, deriv_g;

  // config port
  always_comb begin
    reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_ELEMENT_MODE);
    cfg_pready = 1'b1;
    cfg_prdata = reg_hit ? CFG_DW'(mode_r) : '0;
    mode_nxt   = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      mode_nxt = elem_mode_t'(cfg_pwdata[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BILIN;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign adv = !ctrl_r[NSTG].vld || out_tready;

  qsfd_issue #(.FRAC_BITS(FRAC_BITS)) u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_xi    (in_tdata[XIW-1:0]),
    .in_gamma (in_tdata[2*XIW-1:XIW]),
    .mode     (mode_r),
    .adv      (adv),
    .iss      (iss),
    .iss_x    (iss_x),
    .iss_g    (iss_g),
    .op_x     (op_x),
    .op_g     (op_g)
  );

  qsfd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_xi (
    .clk   (clk),
    .adv   (adv),
    .x     (iss_x),
    .g     (iss_g),
    .op    (op_x),
    .deriv (deriv_x)
  );

  qsfd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_gamma (
    .clk   (clk),
    .adv   (adv),
    .x     (iss_x),
    .g     (iss_g),
    .op    (op_g),
    .deriv (deriv_g)
  );

  // valid, node and last ride alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NSTG; i++) begin
        ctrl_r[i] <= '0;
      end
    end else if (adv) begin
      ctrl_r[1] <= iss;
      for (int i = 2; i <= NSTG; i++) begin
        ctrl_r[i] <= ctrl_r[i-1];
      end
    end
  end

  assign out_tvalid = ctrl_r[NSTG].vld;
  assign out_tlast  = ctrl_r[NSTG].last;
  assign out_tdata  = {{PADW{1'b0}}, deriv_g, deriv_x, ctrl_r[NSTG].node};

  a_last_bilin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && mode_r == MODE_BILIN
      |-> ctrl_r[NSTG].node == NODEW'(NODES_BILIN - 1))
    else $error("last word of a 4-node point has wrong node index");

  a_last_biquad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && mode_r == MODE_BIQUAD
      |-> ctrl_r[NSTG].node == NODEW'(NODES_BIQUAD - 1))
    else $error("last word of a 9-node point has wrong node index");

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> ctrl_r[NSTG].node < NODEW'(NODES_BIQUAD - 1))
    else $error("node index beyond the last node without tlast");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ctrl_r[1]) && $stable(ctrl_r[NSTG]))
    else $error("pipeline moved while the result word was stalled");

  a_node_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast && ctrl_r[NSTG-1].vld
      |=> ctrl_r[NSTG].node == $past(ctrl_r[NSTG].node) + NODEW'(1))
    else $error("node results out of order");

endmodule

// ===== sim/qsfd_checker.sv =====
`timescale 1ns / 100ps
// checker for the quad shape function derivative block: follows the point, result and apb
// channels, predicts every node result and compares it; needs qsfd_pkg only
module qsfd_checker import qsfd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDIN_W-1:0]  in_tdata,    // xi, gamma, zero pad
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDOUT_W-1:0] out_tdata,   // node_index, deriv_xi, deriv_gamma, zero pad
  input  logic               out_tlast,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  input  logic [CFG_DW-1:0]  cfg_prdata,
  input  logic               cfg_pready,
  output int                 mismatches,
  output int                 pending
);

  localparam longint UNIT = longint'(1) <<< FRAC_BITS;

  typedef struct {
    logic [NODEW-1:0] node;
    logic [DW-1:0]    d_xi;
    logic [DW-1:0]    d_gamma;
    logic             last;
  } node_deriv_t;

  node_deriv_t node_derivs_q[$];
  elem_mode_t  elem_mode = MODE_BILIN;
  int          err_cnt = 0;

  function automatic longint clamp_coord(logic [XIW-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > UNIT) v = UNIT;
    else if (v < -UNIT) v = -UNIT;
    return v;
  endfunction

  // round half up: floor(v / 2^s + 1/2)
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_round(longint a, longint b, int s);
    return round_shr(a * b, s);
  endfunction

  function automatic logic [DW-1:0] sat_deriv(longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    else if (v < OUT_MIN) v = OUT_MIN;
    return v[DW-1:0];
  endfunction

  task automatic predict_node_derivs(input logic [XIW-1:0] xi_raw, input logic [XIW-1:0] gm_raw);
    longint x, g, sp, sm, tp, tm, s2, t2;
    longint ss, tt, st, tmg, tpg, smx, spx, ct, cs;
    longint dx [9];
    longint dg [9];
    int n, k;
    node_deriv_t r;
    x  = clamp_coord(xi_raw);
    g  = clamp_coord(gm_raw);
    sp = x + UNIT;
    sm = x - UNIT;
    tp = g + UNIT;
    tm = g - UNIT;
    if (elem_mode == MODE_BILIN) begin
      n = NODES_BILIN;
      dx[0] = round_shr(tm, 2);
      dx[1] = round_shr(-tm, 2);
      dx[2] = round_shr(tp, 2);
      dx[3] = round_shr(-tp, 2);
      dg[0] = round_shr(sm, 2);
      dg[1] = round_shr(-sp, 2);
      dg[2] = round_shr(sp, 2);
      dg[3] = round_shr(-sm, 2);
    end else begin
      n   = NODES_BIQUAD;
      s2  = 2 * x;
      t2  = 2 * g;
      ss  = mul_round(x, x, FRAC_BITS);
      tt  = mul_round(g, g, FRAC_BITS);
      st  = mul_round(x, g, FRAC_BITS);
      tmg = mul_round(tm, g, FRAC_BITS);
      tpg = mul_round(tp, g, FRAC_BITS);
      smx = mul_round(sm, x, FRAC_BITS);
      spx = mul_round(sp, x, FRAC_BITS);
      ct  = UNIT - tt;
      cs  = UNIT - ss;
      // corners: rounded quadratic times linear factor, divided by four
      dx[0] = mul_round(tmg, s2 - UNIT, FRAC_BITS + 2);
      dx[1] = mul_round(tmg, s2 + UNIT, FRAC_BITS + 2);
      dx[2] = mul_round(tpg, s2 + UNIT, FRAC_BITS + 2);
      dx[3] = mul_round(tpg, s2 - UNIT, FRAC_BITS + 2);
      dg[0] = mul_round(smx, t2 - UNIT, FRAC_BITS + 2);
      dg[1] = mul_round(spx, t2 - UNIT, FRAC_BITS + 2);
      dg[2] = mul_round(spx, t2 + UNIT, FRAC_BITS + 2);
      dg[3] = mul_round(smx, t2 + UNIT, FRAC_BITS + 2);
      // midsides
      dx[4] = mul_round(-st, tm, FRAC_BITS);
      dx[5] = mul_round(ct, s2 + UNIT, FRAC_BITS + 1);
      dx[6] = mul_round(-st, tp, FRAC_BITS);
      dx[7] = mul_round(ct, s2 - UNIT, FRAC_BITS + 1);
      dg[4] = mul_round(cs, t2 - UNIT, FRAC_BITS + 1);
      dg[5] = mul_round(-st, sp, FRAC_BITS);
      dg[6] = mul_round(cs, t2 + UNIT, FRAC_BITS + 1);
      dg[7] = mul_round(-st, sm, FRAC_BITS);
      // centre bubble
      dx[8] = mul_round(-s2, ct, FRAC_BITS);
      dg[8] = mul_round(-t2, cs, FRAC_BITS);
    end
    for (k = 0; k < n; k++) begin
      r.node    = NODEW'(k);
      r.d_xi    = sat_deriv(dx[k]);
      r.d_gamma = sat_deriv(dg[k]);
      r.last    = (k == n - 1);
      node_derivs_q.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    node_deriv_t want;
    if (!rst_n) begin
      elem_mode = MODE_BILIN;
      node_derivs_q.delete();
    end else begin
      // results first, so a word that shows up too early has nothing to match
      if (out_tvalid && out_tready) begin
        if (node_derivs_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, expected none, actual %0h last %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = node_derivs_q.pop_front();
          check_field("node_index", 32'(want.node), 32'(out_tdata[NODEW-1:0]));
          check_field("deriv_xi", 32'(want.d_xi), 32'(out_tdata[NODEW +: DW]));
          check_field("deriv_gamma", 32'(want.d_gamma), 32'(out_tdata[NODEW+DW +: DW]));
          check_field("last_node", 32'(want.last), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready)
        predict_node_derivs(in_tdata[XIW-1:0], in_tdata[2*XIW-1:XIW]);
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[CFG_AW-1:2] == REG_ELEMENT_MODE) begin
        if (cfg_pwrite)
          elem_mode = elem_mode_t'(cfg_pwdata[0]);
        else
          check_field("element_mode readback", CFG_DW'(elem_mode), cfg_prdata);
      end
    end
    pending    <= node_derivs_q.size();
    mismatches <= err_cnt;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// top of the quad shape function derivative test: clock, reset, point stimulus, result
// backpressure and apb setup; needs qsfd_pkg, qsfd_checker and the block itself
module testbench import qsfd_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;   // cycles with no word moving
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 12;     // issue plus five stages, with margin
  localparam int SEG_ITEMS   = 14;
  localparam logic [CFG_AW-1:0] ADDR_MODE   = {REG_ELEMENT_MODE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED = 3'h4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDIN_W-1:0]  in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDOUT_W-1:0] out_tdata;
  logic               out_tlast;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [CFG_DW-1:0]  cfg_pwdata = '0;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  int mismatches;
  int pending;
  int send_idle = 31;
  int recv_idle = 47;
  int hold_req = 0;
  int hold_served = 0;

  logic [XIW-1:0] dir_xi [12] = '{18'h00000, 18'h10000, 18'h30000, 18'h10000,
                                  18'h30000, 18'h1FFFF, 18'h10001, 18'h00001,
                                  18'h08000, 18'h15555, 18'h0AAAA, 18'h3FFFF};
  logic [XIW-1:0] dir_gm [12] = '{18'h00000, 18'h10000, 18'h30000, 18'h30000,
                                  18'h10000, 18'h20000, 18'h2FFFF, 18'h3FFFF,
                                  18'h38000, 18'h2AAAA, 18'h35555, 18'h0C000};

  quad_shape_function_derivatives #(.FRAC_BITS(16)) u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  qsfd_checker #(.FRAC_BITS(16)) u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .mismatches, .pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side backpressure, with an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [XIW-1:0] pick_coord();
    logic [XIW-1:0] v;
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      v = XIW'($urandom_range(131072));
      v = v - 18'd65536;
    end else if (r < 85) begin
      v = XIW'($urandom());   // anything, clamping included
    end else begin
      case ($urandom_range(4))
        0: v = 18'h10000;
        1: v = 18'h30000;
        2: v = 18'h00000;
        3: v = 18'h00001;
        default: v = 18'h3FFFF;
      endcase
    end
    return v;
  endfunction

  task automatic send_point(input logic [XIW-1:0] xi, input logic [XIW-1:0] gm);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDIN_W-2*XIW){1'b0}}, gm, xi};
    do @(posedge clk); while (!in_tready);
  endtask

  // let every expected word come out, then give the pipeline time to settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input elem_mode_t m);
    logic [CFG_DW-1:0] d;
    d    = $urandom();
    d[0] = m;
    apb_access(1'b1, ADDR_MODE, d);
    apb_access(1'b0, ADDR_MODE, '0);
  endtask

  initial begin
    int ph, seg, i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, ADDR_MODE, '0);
    for (i = 0; i < 12; i++) send_point(dir_xi[i], dir_gm[i]);
    drain();
    // a write beyond the only register must leave the mode alone
    apb_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF);
    apb_access(1'b0, ADDR_MODE, '0);
    set_mode(MODE_BIQUAD);
    for (i = 0; i < 12; i++) send_point(dir_xi[i], dir_gm[i]);
    drain();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 31; recv_idle = 47; end
        1: begin send_idle = 47; recv_idle = 31; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (seg = 0; seg < 2; seg++) begin
        set_mode(seg == 0 ? MODE_BILIN : MODE_BIQUAD);
        if (ph == 0 && seg == 1) hold_req <= hold_req + 1;
        for (i = 0; i < SEG_ITEMS; i++) send_point(pick_coord(), pick_coord());
        drain();
      end
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/qsfd_pkg.sv
rtl/core/qsfd_issue.sv
rtl/core/qsfd_lane.sv
rtl/core/quad_shape_function_derivatives.sv
sim/qsfd_checker.sv
sim/testbench.sv
